// ----- rtl/core/fis_pkg.sv -----
// fis_pkg: shared types and constants of the frame interval statistics block.
// Used by fis_div and frame_interval_stats; no dependencies.
package fis_pkg;

  localparam int unsigned StampW  = 64;
  localparam int unsigned DeltaW  = 32;
  localparam int unsigned AccW    = 48;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned SpsW    = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  // shared divider: 64-bit dividend, 48-bit divisor, one quotient bit per cycle
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 48;
  localparam int unsigned DivSteps = DivNumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [FreqW-1:0]  FreqReset = 32'd1000000;
  localparam logic [SpsW-1:0]   SpsReset  = 10'd1;
  localparam logic [DeltaW-1:0] Max32     = '1;
  localparam logic [AccW-1:0]   Max48     = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxFreq = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxSps  = 2'd1;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/fis_div.sv -----
// fis_div: iterative restoring divider, one quotient bit per clock.
// Depends on fis_pkg (div_req_t, div_rsp_t, widths).
module fis_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fis_pkg::div_req_t  req_i,
  output fis_pkg::div_rsp_t  rsp_o
);
  import fis_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivDenW-1:0] rem_q, den_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW:0]   trial;
  logic               ge;

  // shift next dividend bit into the partial remainder, subtract if it fits
  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
  assign quo_d = {quo_q[DivNumW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/core/frame_interval_stats.sv -----
// frame_interval_stats: frame deltas, interval min/max/mean, frame rate; uses fis_pkg, fis_div.
// Per item: the first item, or any item with snapshots off, goes straight to the output state;
// others run the threshold divide, on a close the mean divide, and for a nonzero mean the rate.
// Throughput: one item at a time; the next item is taken back in idle, reached as the result
// loads, or later while a stalled result still holds the output register. Divides run 64 steps.
// Reset (async, active low) clears all statistics, snapshots and handshakes.
module frame_interval_stats (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // frame timestamps
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fis_pkg::StampW-1:0]   timestamp_i,
  // per-item results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fis_pkg::DeltaW-1:0]   delta_ticks_o,
  output logic                         snapshot_taken_o,
  output logic [fis_pkg::AccW-1:0]     mean_delta_q16_o,
  output logic [fis_pkg::DeltaW-1:0]   min_delta_o,
  output logic [fis_pkg::DeltaW-1:0]   max_delta_o,
  output logic [fis_pkg::AccW-1:0]     frame_rate_q16_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fis_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fis_pkg::CfgDatW-1:0]  cfg_data_i
);
  import fis_pkg::*;

  typedef enum logic [2:0] {
    StIdle,   // waiting for an item
    StThr,    // threshold = frequency / snapshots_per_second
    StMean,   // mean = sum * 2^16 / count
    StRate,   // rate = frequency * 2^32 / mean
    StOut     // hand result to output register
  } state_e;

  state_e state_q;

  // configuration
  logic [FreqW-1:0] freq_q;
  logic [SpsW-1:0]  sps_q;

  // running statistics
  logic [StampW-1:0] prev_q;
  logic              have_prev_q;
  logic [DeltaW-1:0] count_q;
  logic [AccW-1:0]   sum_q, ticks_q;
  logic [DeltaW-1:0] run_min_q, run_max_q;
  logic [DeltaW-1:0] delta_q;
  logic              snap_flag_q;

  // held snapshot
  logic [AccW-1:0]   snap_mean_q, snap_rate_q;
  logic [DeltaW-1:0] snap_min_q, snap_max_q;

  // output register
  logic              out_valid_q;
  logic [DeltaW-1:0] out_delta_q, out_min_q, out_max_q;
  logic              out_snap_q;
  logic [AccW-1:0]   out_mean_q, out_rate_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_acc, out_free;
  logic [StampW-1:0] diff;
  logic [DeltaW-1:0] delta_new;
  logic [AccW:0]     sum_ext, ticks_ext;
  logic [AccW-1:0]   sum_new, ticks_new;
  logic [AccW-1:0]   mean_sat, rate_sat;
  logic              thr_hit;

  // config writes only between items; a pending write holds off the next item
  assign in_stall_o  = (state_q != StIdle) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == StIdle);

  // wrapping difference, saturated to 32 bits
  assign diff      = timestamp_i - prev_q;
  assign delta_new = (|diff[StampW-1:DeltaW]) ? Max32 : diff[DeltaW-1:0];

  // 48-bit saturating accumulators
  assign sum_ext   = {1'b0, sum_q}   + {{(AccW + 1 - DeltaW){1'b0}}, delta_new};
  assign ticks_ext = {1'b0, ticks_q} + {{(AccW + 1 - DeltaW){1'b0}}, delta_new};
  assign sum_new   = sum_ext[AccW]   ? Max48 : sum_ext[AccW-1:0];
  assign ticks_new = ticks_ext[AccW] ? Max48 : ticks_ext[AccW-1:0];

  // quotient beyond 48 bits saturates, for both mean and rate
  assign mean_sat = (|div_rsp.quotient[DivNumW-1:AccW]) ? Max48 : div_rsp.quotient[AccW-1:0];
  assign rate_sat = mean_sat;
  assign thr_hit  = {{(DivNumW - AccW){1'b0}}, ticks_q} >= div_rsp.quotient;

  // divider launch: threshold on a later accept if sps set, mean on a hit, rate on nonzero mean
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {{(DivNumW - FreqW){1'b0}}, freq_q};
    div_req.divisor  = {{(DivDenW - SpsW){1'b0}}, sps_q};
    unique case (state_q)
      StIdle: begin
        div_req.start = in_acc && have_prev_q && (sps_q != '0);
      end
      StThr: begin
        div_req.start    = div_rsp.done && thr_hit;
        div_req.dividend = {sum_q, 16'h0000};
        div_req.divisor  = {{(DivDenW - DeltaW){1'b0}}, count_q};
      end
      StMean: begin
        div_req.start    = div_rsp.done && (mean_sat != '0);
        div_req.dividend = {freq_q, {(DivNumW - FreqW){1'b0}}};
        div_req.divisor  = mean_sat;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  fis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      freq_q      <= FreqReset;
      sps_q       <= SpsReset;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      ticks_q     <= '0;
      run_min_q   <= Max32;
      run_max_q   <= '0;
      delta_q     <= '0;
      snap_flag_q <= 1'b0;
      snap_mean_q <= '0;
      snap_min_q  <= '0;
      snap_max_q  <= '0;
      snap_rate_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgIdxFreq) begin
          freq_q <= cfg_data_i[FreqW-1:0];
        end else if (cfg_index_i == CfgIdxSps) begin
          sps_q <= cfg_data_i[SpsW-1:0];
        end
      end

      // load a new result, or drop the one just taken
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            prev_q      <= timestamp_i;
            snap_flag_q <= 1'b0;
            if (!have_prev_q) begin
              // first item only records the stamp
              have_prev_q <= 1'b1;
              delta_q     <= '0;
              state_q     <= StOut;
            end else begin
              delta_q <= delta_new;
              if (count_q != Max32) begin
                count_q <= count_q + DeltaW'(1);
              end
              sum_q   <= sum_new;
              ticks_q <= ticks_new;
              if (delta_new < run_min_q) begin
                run_min_q <= delta_new;
              end
              if (delta_new > run_max_q) begin
                run_max_q <= delta_new;
              end
              state_q <= (sps_q != '0) ? StThr : StOut;
            end
          end
        end
        StThr: begin
          if (div_rsp.done) begin
            if (thr_hit) begin
              // close the interval; mean divide latched sum/count this edge
              snap_flag_q <= 1'b1;
              snap_min_q  <= run_min_q;
              snap_max_q  <= run_max_q;
              count_q     <= {{(DeltaW - 1){1'b0}}, 1'b1};
              sum_q       <= {{(AccW - DeltaW){1'b0}}, delta_q};
              ticks_q     <= '0;
              run_min_q   <= delta_q;
              run_max_q   <= delta_q;
              state_q     <= StMean;
            end else begin
              state_q <= StOut;
            end
          end
        end
        StMean: begin
          if (div_rsp.done) begin
            snap_mean_q <= mean_sat;
            if (mean_sat == '0) begin
              snap_rate_q <= Max48;
              state_q     <= StOut;
            end else begin
              state_q <= StRate;
            end
          end
        end
        StRate: begin
          if (div_rsp.done) begin
            snap_rate_q <= rate_sat;
            state_q     <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_free) begin
      out_delta_q <= delta_q;
      out_snap_q  <= snap_flag_q;
      out_mean_q  <= snap_mean_q;
      out_min_q   <= snap_min_q;
      out_max_q   <= snap_max_q;
      out_rate_q  <= snap_rate_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign delta_ticks_o    = out_delta_q;
  assign snapshot_taken_o = out_snap_q;
  assign mean_delta_q16_o = out_mean_q;
  assign min_delta_o      = out_min_q;
  assign max_delta_o      = out_max_q;
  assign frame_rate_q16_o = out_rate_q;

`ifndef SYNTHESIS
  // divider only finishes while the sequencer waits on it
  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StThr || state_q == StMean || state_q == StRate))
    else $error("divider done outside a divide state");

  // divider is free whenever a new item can be taken
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // a closed interval always has min <= max
  a_snap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && snapshot_taken_o) |-> (min_delta_o <= max_delta_o))
    else $error("snapshot min above max");

  // no samples means nothing summed
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with zero count");

  // rate divide never runs on a zero mean
  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRate) |-> (snap_mean_q != '0))
    else $error("rate divide with zero mean");
`endif

endmodule

// ----- tb/sv/frame_interval_stats_tb.sv -----
// frame_interval_stats_tb: self-checking bench for the frame interval statistics block.
// Predicts delta, interval snapshot and frame rate per timestamp item; directed then random.
// Depends on fis_pkg and the frame_interval_stats RTL.
module frame_interval_stats_tb;
  import fis_pkg::*;

  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 250;        // longer than a three-divide item
  localparam int unsigned RandomBlocks = 12;
  localparam int unsigned BlockItems   = 156;
  localparam int unsigned PrintLimit   = 40;

  // index 3 is not mapped; a write there must change nothing
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic              snap;
    logic [AccW-1:0]   mean;
    logic [DeltaW-1:0] min_d;
    logic [DeltaW-1:0] max_d;
    logic [AccW-1:0]   rate;
  } frame_stats_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              in_valid_i;
  logic              in_stall_o;
  logic [StampW-1:0] timestamp_i;

  logic              out_valid_o;
  logic              out_stall_i;
  logic [DeltaW-1:0] delta_ticks_o;
  logic              snapshot_taken_o;
  logic [AccW-1:0]   mean_delta_q16_o;
  logic [DeltaW-1:0] min_delta_o;
  logic [DeltaW-1:0] max_delta_o;
  logic [AccW-1:0]   frame_rate_q16_o;

  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  frame_interval_stats DUT (.*);

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers plus the interval accumulators
  // ---------------------------------------------------------------------------
  logic [FreqW-1:0]  ticks_per_sec = FreqReset;
  logic [SpsW-1:0]   snaps_per_sec = SpsReset;
  logic [StampW-1:0] last_seen_stamp = '0;
  logic              seen_first = 1'b0;
  logic [DeltaW-1:0] frame_count = '0;
  logic [AccW-1:0]   delta_total = '0;
  logic [DeltaW-1:0] low_delta = Max32;
  logic [DeltaW-1:0] high_delta = '0;
  logic [AccW-1:0]   elapsed_ticks = '0;
  logic [AccW-1:0]   held_mean = '0;
  logic [DeltaW-1:0] held_min = '0;
  logic [DeltaW-1:0] held_max = '0;
  logic [AccW-1:0]   held_rate = '0;

  // expected results, oldest first; every accepted timestamp yields exactly one
  frame_stats_t stats_pending[$];

  logic              quiet;          // no idling on either side while set
  logic [StampW-1:0] stream_stamp;   // last timestamp handed to the block
  int unsigned       mismatch_count = 0;
  int unsigned       results_checked = 0;
  int unsigned       frames_sent = 0;
  int unsigned       closes_seen = 0;
  int unsigned       writes_done = 0;
  int unsigned       cycle_count = 0;

  function automatic logic [AccW-1:0] sat_add48(logic [AccW-1:0] acc, logic [DeltaW-1:0] add);
    logic [AccW:0] sum;
    sum = (AccW + 1)'(acc) + (AccW + 1)'(add);
    return sum[AccW] ? Max48 : sum[AccW-1:0];
  endfunction

  // one timestamp through the predictor; updates the shadow state
  function automatic frame_stats_t predict_frame(logic [StampW-1:0] stamp);
    logic [63:0]       diff, limit, quo, rem, frac, packed_mean, rate_full;
    logic [DeltaW-1:0] delta;
    logic              closes;
    delta  = '0;
    closes = 1'b0;
    if (!seen_first) begin
      // first item after reset only latches the stamp
      seen_first = 1'b1;
    end else begin
      diff  = stamp - last_seen_stamp;  // wraps modulo 2^64
      delta = (diff > 64'(Max32)) ? Max32 : diff[DeltaW-1:0];
      if (frame_count != Max32) frame_count++;
      delta_total   = sat_add48(delta_total, delta);
      elapsed_ticks = sat_add48(elapsed_ticks, delta);
      if (delta < low_delta) low_delta = delta;
      if (delta > high_delta) high_delta = delta;
      limit = (snaps_per_sec != '0) ? 64'(ticks_per_sec) / 64'(snaps_per_sec) : '0;
      if (snaps_per_sec != '0 && 64'(elapsed_ticks) >= limit) begin
        closes = 1'b1;
        // Q32.16 mean: integer and fraction parts divided separately
        quo  = 64'(delta_total) / 64'(frame_count);
        rem  = 64'(delta_total) % 64'(frame_count);
        frac = (rem << 16) / 64'(frame_count);
        packed_mean = (quo << 16) | frac;
        held_mean = (quo > 64'(Max32)) ? Max48 : packed_mean[AccW-1:0];
        held_min  = low_delta;
        held_max  = high_delta;
        if (held_mean == '0) begin
          held_rate = Max48;
        end else begin
          rate_full = {ticks_per_sec, 32'h0} / 64'(held_mean);
          held_rate = (rate_full > 64'(Max48)) ? Max48 : rate_full[AccW-1:0];
        end
        // next interval opens with this delta as its only sample
        frame_count   = DeltaW'(1);
        delta_total   = AccW'(delta);
        low_delta     = delta;
        high_delta    = delta;
        elapsed_ticks = '0;
      end
    end
    last_seen_stamp = stamp;
    return '{delta, closes, held_mean, held_min, held_max, held_rate};
  endfunction

  function automatic int unsigned idle_draw();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Timestamp channel. Valid stays high across back-to-back items; it is only
  // lowered when a gap is drawn or by wait_idle, so it never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_stamp(input logic [StampW-1:0] stamp);
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    timestamp_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    stream_stamp = stamp;
    stats_pending.push_back(predict_frame(stamp));
    if (stats_pending[$].snap) closes_seen++;
    frames_sent++;
  endtask

  // stop sending until every expected result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stats_pending.size() != 0);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgIdxFreq: ticks_per_sec = data[FreqW-1:0];
      CfgIdxSps:  snaps_per_sec = data[SpsW-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic set_rates(input logic [CfgDatW-1:0] freq, input logic [CfgDatW-1:0] sps);
    write_reg(CfgIdxFreq, freq);
    write_reg(CfgIdxSps, sps);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per result, checked against the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin : drive_result_stall
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = idle_draw();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_pending.size() == 0) begin
        report_mismatch("result with no frame outstanding");
      end else begin
        want = stats_pending.pop_front();
        if (delta_ticks_o !== want.delta)
          report_mismatch($sformatf("item %0d delta_ticks %0h, expected %0h",
                                    results_checked, delta_ticks_o, want.delta));
        if (snapshot_taken_o !== want.snap)
          report_mismatch($sformatf("item %0d snapshot_taken %0b, expected %0b",
                                    results_checked, snapshot_taken_o, want.snap));
        if (mean_delta_q16_o !== want.mean)
          report_mismatch($sformatf("item %0d mean_delta_q16 %0h, expected %0h",
                                    results_checked, mean_delta_q16_o, want.mean));
        if (min_delta_o !== want.min_d)
          report_mismatch($sformatf("item %0d min_delta %0h, expected %0h",
                                    results_checked, min_delta_o, want.min_d));
        if (max_delta_o !== want.max_d)
          report_mismatch($sformatf("item %0d max_delta %0h, expected %0h",
                                    results_checked, max_delta_o, want.max_d));
        if (frame_rate_q16_o !== want.rate)
          report_mismatch($sformatf("item %0d frame_rate_q16 %0h, expected %0h",
                                    results_checked, frame_rate_q16_o, want.rate));
      end
      results_checked++;
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, stats_pending.size());
      $display("FAIL frame_interval_stats");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (1 MHz, one snapshot per second): first item, wrap of the
  // 64-bit counter, zero delta, exact threshold hit, saturation at 32 bits.
  task automatic test_reset_defaults();
    send_stamp(64'hFFFF_FFFF_FFFF_FFF0);     // only latched
    send_stamp(stream_stamp + 64'h20);       // wraps past zero
    send_stamp(stream_stamp);                // zero delta
    send_stamp(stream_stamp + 64'd1);
    send_stamp(stream_stamp + 64'd999_900);  // just short of a second
    send_stamp(stream_stamp + 64'd67);       // elapsed lands exactly on 1e6
    send_stamp(stream_stamp + 64'hFFFF_FFFF);
    send_stamp(stream_stamp + 64'h1_0000_0000);  // one past 32 bits saturates
    send_stamp(stream_stamp - 64'd5);        // counter went backwards
    send_stamp(64'h0);
    send_stamp(64'hAAAA_5555_AAAA_5555);
  endtask

  // Register extremes: zero frequency, threshold below one tick, largest
  // frequency with the highest rate code, snapshots disabled.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CfgIdxSpare, Max32);           // unmapped, must be ignored
    set_rates(32'd0, 32'd1);                 // every item closes, rate 0
    send_stamp(stream_stamp);
    send_stamp(stream_stamp);                // zero mean: rate pegs at max
    send_stamp(stream_stamp + 64'd5);

    wait_idle();
    set_rates(32'd1, {22'h3F_FFFF, 10'd1000});  // upper data bits dropped
    send_stamp(stream_stamp);
    send_stamp(stream_stamp + 64'd1);
    send_stamp(stream_stamp + 64'd3);

    wait_idle();
    set_rates(Max32, 32'd1023);              // threshold 4198404 ticks
    send_stamp(stream_stamp + 64'd4_198_403);
    send_stamp(stream_stamp + 64'd1);
    send_stamp(stream_stamp);

    wait_idle();
    set_rates(FreqReset, 32'd0);             // snapshots off, held values stay
    send_stamp(stream_stamp + 64'hFFFF_FFFF);
    send_stamp(stream_stamp + 64'h100_0000_0000);
    send_stamp(~stream_stamp);
  endtask

  // next timestamp for the random stream, with advances scaled to the current threshold
  function automatic logic [StampW-1:0] next_stamp();
    logic [63:0] limit, span, advance;
    int unsigned pick;
    if (snaps_per_sec != '0) limit = 64'(ticks_per_sec) / 64'(snaps_per_sec);
    else limit = 64'(ticks_per_sec);
    span = limit / 64'd6 + 64'd1;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      advance = {$urandom, $urandom} % (span + 64'd1);
    end else if (pick < 62) begin
      advance = 64'($urandom_range(0, 3));
    end else if (pick < 77) begin
      advance = (limit >= 64'd2) ? limit - 64'd2 + 64'($urandom_range(0, 4))
                                 : 64'($urandom_range(0, 4));
    end else if (pick < 87) begin
      // around and beyond the 32-bit saturation point
      if ($urandom_range(0, 1) == 0)
        advance = 64'h1_0000_0000 + 64'($urandom_range(0, 2)) - 64'd1;
      else advance = {$urandom, $urandom} >> $urandom_range(0, 31);
    end else if (pick < 94) begin
      return stream_stamp - 64'($urandom_range(1, 1000));
    end else begin
      return {$urandom, $urandom};
    end
    return stream_stamp + advance;
  endfunction

  // Random stream in blocks; each block drains, then picks new rates. The first
  // eight blocks walk through the eight rate cases in order, the rest pick a case at random.
  task automatic test_random_frames();
    int unsigned sel;
    logic [CfgDatW-1:0] freq, sps;
    for (int unsigned b = 0; b < RandomBlocks; b++) begin
      wait_idle();
      sel = (b < 8) ? b : $urandom_range(0, 7);
      case (sel)
        0: begin freq = '0;                             sps = $urandom_range(1, 1023); end
        1: begin freq = 32'd1;                          sps = 32'd1000;                end
        2: begin freq = Max32;                          sps = 32'd1;                   end
        3: begin freq = Max32;                          sps = 32'd1023;                end
        4: begin freq = $urandom;                       sps = $urandom;                end
        5: begin freq = $urandom_range(1000, 100_000);  sps = $urandom_range(1, 1000); end
        6: begin freq = FreqReset;                      sps = '0;                      end
        default: begin freq = $urandom;                 sps = 32'd1000;                end
      endcase
      set_rates(freq, sps);
      for (int unsigned i = 0; i < BlockItems; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_stamp(next_stamp());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    timestamp_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgIdxFreq;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    stream_stamp = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_frames();

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d frames checked, %0d interval closes, %0d register writes",
             results_checked, closes_seen, writes_done);
    $display("covered counter wrap, 32-bit saturation, zero and max rates, disabled snapshots");
    if (mismatch_count == 0) begin
      $display("PASS frame_interval_stats");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL frame_interval_stats");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fis_pkg.sv
rtl/core/fis_div.sv
rtl/core/frame_interval_stats.sv
tb/sv/frame_interval_stats_tb.sv
